FILE: design/assert_macros.svh
// Assertion helpers shared by the RTL. Every property is sampled on the rising
// edge of clk and is switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A condition at one edge implies a consequence at the next edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/col_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package col_pkg;

	localparam int DEPTH      = 16;
	localparam int ENTRY_BITS = 64;

	// Widths of the item fields.
	localparam int OP_W    = 3;
	localparam int POS_W   = 4;
	localparam int VALUE_W = 64;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	// Internal widths that follow from the list depth.
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND       = 3'd0,
		OP_SET          = 3'd1,
		OP_GET          = 3'd2,
		OP_REMOVE_AT    = 3'd3,
		OP_FIND         = 3'd4,
		OP_REMOVE_VALUE = 3'd5,
		OP_CLEAR        = 3'd6
	} col_op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} col_status_t;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [POS_W-1:0]   position;
		logic [VALUE_W-1:0] entry_value;
	} col_cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [POS_W-1:0]   found_index;
		logic [VALUE_W-1:0] read_value;
		logic [COUNT_W-1:0] entry_count;
	} col_rsp_t;

	// Broadcast from the controller to every cell of the chain.
	typedef struct packed {
		logic                  append_en;
		logic                  set_en;
		logic                  rm_at;
		logic                  rm_val;
		logic [IDX_W-1:0]      pos;
		logic [CNT_W-1:0]      count;
		logic [ENTRY_BITS-1:0] value;
	} col_cell_ctl_t;

endpackage

`default_nettype wire

FILE: design/col_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface col_cmd_if;
	import col_pkg::*;

	logic     valid;
	logic     ready;
	col_cmd_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: design/col_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface col_rsp_if;
	import col_pkg::*;

	logic     valid;
	logic     ready;
	col_rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: design/col_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module col_cell (
	input  wire logic                          clk,
	input  wire col_pkg::col_cell_ctl_t        ctl,
	input  wire logic [col_pkg::IDX_W-1:0]     cell_index,
	input  wire logic [col_pkg::ENTRY_BITS-1:0] next_entry,
	input  wire logic                          hit_in,
	output      logic [col_pkg::ENTRY_BITS-1:0] entry,
	output      logic                          hit_out,
	output      logic                          first
);
	import col_pkg::*;

	logic [ENTRY_BITS-1:0] entry_q;
	logic                  occupied;
	logic                  match;
	logic                  shift;

	assign occupied = CNT_W'(cell_index) < ctl.count;
	assign match    = occupied && (entry_q == ctl.value);
	assign hit_out  = hit_in || match;
	assign first    = match && !hit_in;

	// On a removal every cell from the removed one upward takes its upper neighbor.
	assign shift = (ctl.rm_at && (cell_index >= ctl.pos)) || (ctl.rm_val && hit_out);

	always_ff @(posedge clk) begin
		if (ctl.append_en && (CNT_W'(cell_index) == ctl.count)) begin
			entry_q <= ctl.value;
		end else if (ctl.set_en && (cell_index == ctl.pos)) begin
			entry_q <= ctl.value;
		end else if (shift) begin
			entry_q <= next_entry;
		end
	end

	assign entry = entry_q;

endmodule

`default_nettype wire

FILE: design/compacting_ordered_list.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Channel  Modport  Payload fields
// cmd      sink     operation, position, entry_value
// rsp      source   status, found_index, read_value, entry_count
//
// Each command item gives exactly one response item, registered in the cycle after it is taken.
// A new command is taken in every cycle in which the response register is empty
// or is being emptied; the combinational compare across the cell chain and the shift
// done at the accepting edge set that rate of one item per cycle.
// Reset clears the entry count and the response valid; entry storage is not reset.
// A stalled response holds its register and blocks new commands until taken.
module compacting_ordered_list (
	input wire logic  clk,
	input wire logic  arst_n,
	col_cmd_if.sink   cmd,
	col_rsp_if.source rsp
);
	import col_pkg::*;

	// Entry count and the registered response.
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	col_rsp_t         rsp_q;
	logic             rsp_valid_q;

	logic acc;

	// Chain signals: each cell sees the entry of its upper neighbor and the
	// running "already matched below" bit from its lower neighbor.
	col_cell_ctl_t         ctl;
	logic [ENTRY_BITS-1:0] entries_w [DEPTH];
	logic [DEPTH:0]        hit_w;
	logic [DEPTH-1:0]      first_w;
	logic [IDX_W-1:0]      hit_idx;

	logic [IDX_W-1:0]      pos_idx;
	logic                  pos_ok;
	logic                  full;
	col_status_t           st;
	logic [IDX_W-1:0]      idx_out;
	logic [ENTRY_BITS-1:0] rd;

	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign acc       = cmd.valid && cmd.ready;

	// The index is only used where it is known to be below the count.
	assign pos_idx = IDX_W'(cmd.payload.position);
	assign pos_ok  = CMP_W'(cmd.payload.position) < CMP_W'(count_q);
	assign full    = count_q >= CNT_W'(DEPTH);

	// Cell enables depend only on the command and the count, never on the search.
	always_comb begin
		ctl           = '0;
		ctl.pos       = pos_idx;
		ctl.count     = count_q;
		ctl.value     = cmd.payload.entry_value[ENTRY_BITS-1:0];
		ctl.append_en = acc && (cmd.payload.operation == OP_APPEND) && !full;
		ctl.set_en    = acc && (cmd.payload.operation == OP_SET) && pos_ok;
		ctl.rm_at     = acc && (cmd.payload.operation == OP_REMOVE_AT) && pos_ok;
		ctl.rm_val    = acc && (cmd.payload.operation == OP_REMOVE_VALUE);
	end

	assign hit_w[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [ENTRY_BITS-1:0] upper;
		if (i == DEPTH - 1) begin : g_top
			assign upper = '0;
		end else begin : g_mid
			assign upper = entries_w[i+1];
		end
		col_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.cell_index (IDX_W'(i)),
			.next_entry (upper),
			.hit_in     (hit_w[i]),
			.entry      (entries_w[i]),
			.hit_out    (hit_w[i+1]),
			.first      (first_w[i])
		);
	end

	// At most one cell reports the first match, so its index is an OR of all.
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (first_w[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
		end
	end

	always_comb begin
		st      = ST_OK;
		idx_out = '0;
		rd      = '0;
		count_d = count_q;
		case (cmd.payload.operation)
			OP_APPEND: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					idx_out = count_q[IDX_W-1:0];
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_SET: begin
				if (!pos_ok) begin
					st = ST_BAD_INDEX;
				end else begin
					idx_out = pos_idx;
				end
			end
			OP_GET: begin
				if (!pos_ok) begin
					st = ST_BAD_INDEX;
				end else begin
					idx_out = pos_idx;
					rd      = entries_w[pos_idx];
				end
			end
			OP_REMOVE_AT: begin
				if (!pos_ok) begin
					st = ST_BAD_INDEX;
				end else begin
					idx_out = pos_idx;
					count_d = count_q - CNT_W'(1);
				end
			end
			OP_FIND: begin
				if (!hit_w[DEPTH]) begin
					st = ST_NOT_FOUND;
				end else begin
					idx_out = hit_idx;
				end
			end
			OP_REMOVE_VALUE: begin
				if (!hit_w[DEPTH]) begin
					st = ST_NOT_FOUND;
				end else begin
					idx_out = hit_idx;
					count_d = count_q - CNT_W'(1);
				end
			end
			OP_CLEAR: begin
				count_d = '0;
			end
			default: begin
				// The unused code leaves everything as it is.
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else if (acc) begin
			count_q     <= count_d;
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rsp_q.status      <= st;
			rsp_q.found_index <= POS_W'(idx_out);
			rsp_q.read_value  <= VALUE_W'(rd);
			rsp_q.entry_count <= COUNT_W'(count_d);
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	`ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(DEPTH), "entry count above depth")
	`ASSERT_ALWAYS(a_first_unique, $onehot0(first_w), "more than one first match")
	`ASSERT_NEXT(a_rsp_count, acc, rsp_q.entry_count == COUNT_W'(count_q), "response count mismatch")
	`ASSERT_NEXT(a_clear, acc && (cmd.payload.operation == OP_CLEAR), count_q == '0, "clear left entries")

endmodule

`default_nettype wire
